// ===== rtl/thstf_pkg.sv =====
// shared constants and types for the triangle conduction stiffness block
package thstf_pkg;

	localparam int COORD_W_DEF = 32;
	localparam int K_W = 32;
	localparam logic [K_W-1:0] K_RESET = 32'd65536;
	localparam int OUT_W = 48;
	// quotient bits resolved by the divider before rounding
	localparam int QB = 49;
	// q.32 products times q16.16 conductivity to q24.24 result
	localparam int FRAC_SHIFT = 7;
	localparam int NPAIR = 6;
	localparam int NGRAD = 3;
	// gradient pairs of the upper triangle, row-major
	localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
	localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

	typedef struct packed {
		logic is_tri;
		logic zero;
	} item_ctl_t;

endpackage

// ===== rtl/thstf_div.sv =====
// pipelined restoring divider with round-half-away and signed saturation
module thstf_div #(
	parameter int NUM_W = 105,
	parameter int DEN_W = 66
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NUM_W-1:0]            num,
	input  logic [DEN_W-1:0]            den,
	input  logic                        neg,
	output logic [thstf_pkg::OUT_W-1:0] res
);

	localparam int QB = thstf_pkg::QB;
	localparam int OUT_W = thstf_pkg::OUT_W;
	localparam logic [QB:0] LIM_NEG = (QB+1)'(1) << (OUT_W - 1);
	localparam logic [QB:0] LIM_POS = LIM_NEG - (QB+1)'(1);

	logic [DEN_W-1:0] rem_s [QB+1];
	logic [DEN_W-1:0] den_s [QB+1];
	logic [QB-1:0]    lo_s  [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic             ovf_s [QB+1];
	logic             neg_s [QB+1];

	logic [DEN_W-1:0] hi_ext;
	logic             hi_ovf;
	logic [QB:0]      qr_sr;
	logic             ovf_sr;
	logic             neg_sr;
	logic [QB:0]      lim;
	logic [QB:0]      mag;
	logic             rup;
	logic [OUT_W-1:0] res_so;

	// quotient too large for the resolved bits when the top part already reaches den
	assign hi_ext = DEN_W'(num[NUM_W-1:QB]);
	assign hi_ovf = (hi_ext >= den);

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi_ovf;
			rem_s[0] <= hi_ovf ? '0 : hi_ext;
			lo_s[0]  <= num[QB-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		assign trial = {rem_s[i], lo_s[i][QB-1-i]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign ge    = (trial >= {1'b0, den_s[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_s[i+1] <= {quo_s[i][QB-2:0], ge};
				lo_s[i+1]  <= lo_s[i];
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// round up when twice the remainder reaches the divisor
	assign rup = ({rem_s[QB], 1'b0} >= {1'b0, den_s[QB]});

	always_ff @(posedge clk) begin
		if (en) begin
			qr_sr  <= {1'b0, quo_s[QB]} + (QB+1)'(rup);
			ovf_sr <= ovf_s[QB];
			neg_sr <= neg_s[QB];
		end
	end

	assign lim = neg_sr ? LIM_NEG : LIM_POS;
	assign mag = (ovf_sr || (qr_sr > lim)) ? lim : qr_sr;

	always_ff @(posedge clk) begin
		if (en) begin
			res_so <= neg_sr ? (~mag[OUT_W-1:0] + 1'b1) : mag[OUT_W-1:0];
		end
	end

	assign res = res_so;

endmodule

// ===== rtl/triangle_heat_stiffness.sv =====
// top level: linear triangle heat conduction stiffness matrix pipeline
//
// usage
//  - input channel in_valid/in_ready carries one triangle per beat: three
//    corner coordinates (signed q16.16, COORD_WIDTH bits) and is_triangle
//  - output channel out_valid/out_ready carries the symmetric 3x3 matrix
//    m00..m22 (signed q24.24, saturating) and the degenerate flag
//  - cfg_valid/cfg_ready writes the conductivity (unsigned q16.16); cfg_ready
//    is always high, write only while no beat is in flight
//  - pipeline: six arithmetic stages, a 52-stage divider, one output
//    register between input beat and output beat
//  - throughput: one beat per cycle while the receiver keeps up; every stage
//    is a register slice, the divider resolves one quotient bit per stage
//  - a stalled receiver freezes the whole pipeline; in_ready follows the
//    output register being empty or taken, so nothing is lost or repeated
//  - reset clears all valid bits and sets conductivity to 1.0
//  - a zero determinant gives a zero matrix with degenerate set; a beat not
//    marked as a triangle gives all zeros
module triangle_heat_stiffness #(
	parameter int COORD_WIDTH = thstf_pkg::COORD_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] x_a,
	input  logic signed [COORD_WIDTH-1:0] y_a,
	input  logic signed [COORD_WIDTH-1:0] x_b,
	input  logic signed [COORD_WIDTH-1:0] y_b,
	input  logic signed [COORD_WIDTH-1:0] x_c,
	input  logic signed [COORD_WIDTH-1:0] y_c,
	input  logic                          is_triangle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [47:0]            m00,
	output logic signed [47:0]            m01,
	output logic signed [47:0]            m02,
	output logic signed [47:0]            m10,
	output logic signed [47:0]            m11,
	output logic signed [47:0]            m12,
	output logic signed [47:0]            m20,
	output logic signed [47:0]            m21,
	output logic signed [47:0]            m22,
	output logic                          degenerate,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [31:0]                   cfg_data
);

	localparam int K_W = thstf_pkg::K_W;
	localparam int OUT_W = thstf_pkg::OUT_W;
	localparam int NPAIR = thstf_pkg::NPAIR;
	localparam int NGRAD = thstf_pkg::NGRAD;
	localparam int DW = COORD_WIDTH + 1;       // coordinate difference
	localparam int PW = 2 * DW;                // one product
	localparam int SW = PW + 1;                // sum or difference of products
	localparam int MW = PW;                    // magnitude of that sum
	localparam int NCH = (MW + 31) / 32;       // 32-bit chunks for the k multiply
	localparam int PADW = NCH * 32;
	localparam int NUM_W = MW + K_W + thstf_pkg::FRAC_SHIFT;
	localparam int DL = thstf_pkg::QB + 2;     // last index of the flag delay line beside the divider

	logic en;
	logic [K_W-1:0] k_q;

	// stage 1: gradients (adjugate rows)
	logic signed [DW-1:0] gx_s1 [NGRAD];
	logic signed [DW-1:0] gy_s1 [NGRAD];
	logic                 v_s1, tri_s1;
	// stage 2: exact products
	logic signed [PW-1:0] px_s2 [NPAIR];
	logic signed [PW-1:0] py_s2 [NPAIR];
	logic signed [PW-1:0] deta_s2, detb_s2;
	logic                 v_s2, tri_s2;
	// stage 3: dot products and determinant
	logic signed [SW-1:0] dot_s3 [NPAIR];
	logic signed [SW-1:0] det_s3;
	logic                 v_s3, tri_s3;
	// stage 4: magnitudes
	logic [MW-1:0]        dmag_s4 [NPAIR];
	logic                 neg_s4 [NPAIR];
	logic [MW-1:0]        den_s4;
	thstf_pkg::item_ctl_t ctl_s4;
	logic                 v_s4;
	// stage 5: partial products with conductivity
	logic [63:0]          pp_s5 [NPAIR][NCH];
	logic                 neg_s5 [NPAIR];
	logic [MW-1:0]        den_s5;
	thstf_pkg::item_ctl_t ctl_s5;
	logic                 v_s5;
	// stage 6: numerators
	logic [NUM_W-1:0]     num_s6 [NPAIR];
	logic                 neg_s6 [NPAIR];
	logic [MW-1:0]        den_s6;
	thstf_pkg::item_ctl_t ctl_s6;
	logic                 v_s6;
	// flags riding alongside the divider
	thstf_pkg::item_ctl_t ctl_d [DL+1];
	logic                 v_d [DL+1];
	logic [OUT_W-1:0]     res [NPAIR];

	logic signed [DW-1:0] xa_e, ya_e, xb_e, yb_e, xc_e, yc_e;

	// whole pipeline moves when the output register is free or being taken
	assign en = out_ready | ~out_valid;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= thstf_pkg::K_RESET;
		end else if (cfg_valid) begin
			k_q <= cfg_data;
		end
	end

	assign xa_e = $signed({x_a[COORD_WIDTH-1], x_a});
	assign ya_e = $signed({y_a[COORD_WIDTH-1], y_a});
	assign xb_e = $signed({x_b[COORD_WIDTH-1], x_b});
	assign yb_e = $signed({y_b[COORD_WIDTH-1], y_b});
	assign xc_e = $signed({x_c[COORD_WIDTH-1], x_c});
	assign yc_e = $signed({y_c[COORD_WIDTH-1], y_c});

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i <= DL; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_d[0] <= v_s6;
			for (int i = 1; i <= DL; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	// stages 1 to 4, plus determinant and flags through stages 5 and 6
	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1[0] <= yb_e - yc_e;
			gx_s1[1] <= yc_e - ya_e;
			gx_s1[2] <= ya_e - yb_e;
			gy_s1[0] <= xc_e - xb_e;
			gy_s1[1] <= xa_e - xc_e;
			gy_s1[2] <= xb_e - xa_e;
			tri_s1   <= is_triangle;

			// det = (xb-xa)(yc-ya) - (xc-xa)(yb-ya)
			deta_s2 <= gy_s1[2] * gx_s1[1];
			detb_s2 <= gy_s1[1] * gx_s1[2];
			tri_s2  <= tri_s1;

			det_s3 <= SW'(deta_s2) - SW'(detb_s2);
			tri_s3 <= tri_s2;

			den_s4 <= det_s3[SW-1] ? MW'(-det_s3) : MW'(det_s3);
			ctl_s4.is_tri <= tri_s3;
			ctl_s4.zero   <= (det_s3 == '0);

			den_s5 <= den_s4;
			ctl_s5 <= ctl_s4;
			den_s6 <= den_s5;
			ctl_s6 <= ctl_s5;
		end
	end

	for (genvar p = 0; p < NPAIR; p++) begin : g_pair
		logic [PADW-1:0]   pad;
		logic [PADW+31:0]  acc;

		assign pad = PADW'(dmag_s4[p]);

		always_comb begin
			acc = '0;
			for (int c = 0; c < NCH; c++) begin
				acc = acc + ((PADW+32)'(pp_s5[p][c]) << (32 * c));
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				px_s2[p] <= gx_s1[thstf_pkg::PAIR_I[p]] * gx_s1[thstf_pkg::PAIR_J[p]];
				py_s2[p] <= gy_s1[thstf_pkg::PAIR_I[p]] * gy_s1[thstf_pkg::PAIR_J[p]];
				dot_s3[p] <= SW'(px_s2[p]) + SW'(py_s2[p]);
				dmag_s4[p] <= dot_s3[p][SW-1] ? MW'(-dot_s3[p]) : MW'(dot_s3[p]);
				neg_s4[p] <= dot_s3[p][SW-1];
				neg_s5[p] <= neg_s4[p];
				num_s6[p] <= {acc[MW+K_W-1:0], {thstf_pkg::FRAC_SHIFT{1'b0}}};
				neg_s6[p] <= neg_s5[p];
			end
		end

		// one 32x32 partial product per chunk of the dot magnitude
		for (genvar c = 0; c < NCH; c++) begin : g_chunk
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s5[p][c] <= 64'(pad[c*32 +: 32]) * 64'(k_q);
				end
			end
		end

		thstf_div #(
			.NUM_W (NUM_W),
			.DEN_W (MW)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s6[p]),
			.den (den_s6),
			.neg (neg_s6[p]),
			.res (res[p])
		);
	end

	// item flags delayed to meet the divider results
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_d[0] <= ctl_s6;
			for (int i = 1; i <= DL; i++) begin
				ctl_d[i] <= ctl_d[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_d[DL];
		end
	end

	// output register, matrix is symmetric
	logic live;
	assign live = ctl_d[DL].is_tri & ~ctl_d[DL].zero;

	always_ff @(posedge clk) begin
		if (en) begin
			m00 <= live ? res[0] : '0;
			m01 <= live ? res[1] : '0;
			m02 <= live ? res[2] : '0;
			m10 <= live ? res[1] : '0;
			m11 <= live ? res[3] : '0;
			m12 <= live ? res[4] : '0;
			m20 <= live ? res[2] : '0;
			m21 <= live ? res[4] : '0;
			m22 <= live ? res[5] : '0;
			degenerate <= ctl_d[DL].is_tri & ctl_d[DL].zero;
		end
	end

endmodule

// ===== tb/tb.sv =====
// self-checking bench for the triangle conduction stiffness pipeline
module tb;

	typedef logic signed [191:0] wide_t;
	typedef logic signed [31:0] crd_t;

	// one expected output beat: matrix in row-major order and the degenerate flag
	typedef struct packed {
		logic [8:0][thstf_pkg::OUT_W-1:0] m;
		logic                             deg;
	} stiff_t;

	localparam int LATENCY = 59;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	crd_t x_a = '0, y_a = '0, x_b = '0, y_b = '0, x_c = '0, y_c = '0;
	logic is_triangle = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [47:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic degenerate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	stiff_t matrix_q[$];
	logic [thstf_pkg::K_W-1:0] k_model = thstf_pkg::K_RESET;
	int errors = 0;
	int cycles = 0;
	// when set, neither side idles
	logic no_idle = 1'b0;

	triangle_heat_stiffness u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b), .x_c(x_c), .y_c(y_c),
		.is_triangle(is_triangle),
		.out_valid(out_valid), .out_ready(out_ready),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// exact stiffness: k * (gi . gj) * 2^7 / |det|, rounded half away, saturated
	function automatic stiff_t stiffness_of(crd_t xa, crd_t ya, crd_t xb, crd_t yb,
			crd_t xc, crd_t yc, logic marked, logic [thstf_pkg::K_W-1:0] k);
		stiff_t res;
		wide_t ax, ay, bx, by, cx, cy, det, dmag, dot, num, q, r, lim, kw;
		wide_t gx[3], gy[3];
		logic neg;
		res = '0;
		ax = wide_t'(xa); ay = wide_t'(ya);
		bx = wide_t'(xb); by = wide_t'(yb);
		cx = wide_t'(xc); cy = wide_t'(yc);
		kw = wide_t'({160'd0, k});
		if (marked) begin
			det = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
			if (det == 0) begin
				res.deg = 1'b1;
			end else begin
				dmag = (det < 0) ? -det : det;
				gx[0] = by - cy; gx[1] = cy - ay; gx[2] = ay - by;
				gy[0] = cx - bx; gy[1] = ax - cx; gy[2] = bx - ax;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						dot = gx[i] * gx[j] + gy[i] * gy[j];
						neg = dot < 0;
						num = (((dot < 0) ? -dot : dot) * kw) <<< thstf_pkg::FRAC_SHIFT;
						q = num / dmag;
						r = num % dmag;
						if (2 * r >= dmag) q = q + 1;
						lim = neg ? (wide_t'(1) <<< 47) : (wide_t'(1) <<< 47) - 1;
						if (q > lim) q = lim;
						if (neg) q = -q;
						// m00 sits in the top slot, as in the concatenation of the ports
						res.m[8 - (i * 3 + j)] = q[thstf_pkg::OUT_W-1:0];
					end
				end
			end
		end
		return res;
	endfunction

	// result checker against the oldest expected matrix
	always @(posedge clk) begin
		stiff_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.m = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
			got.deg = degenerate;
			if (matrix_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat: %h", got);
			end else begin
				want = matrix_q.pop_front();
				for (int e = 0; e < 9; e++) begin
					if (got.m[8 - e] !== want.m[8 - e]) begin
						errors++;
						if (errors <= 10)
							$display("m%0d%0d: expected %h got %h", e / 3, e % 3,
								want.m[8 - e], got.m[8 - e]);
					end
				end
				if (got.deg !== want.deg) begin
					errors++;
					if (errors <= 10)
						$display("degenerate: expected %b got %b", want.deg, got.deg);
				end
			end
		end
	end

	// receiver idling, changed on the falling edge
	always @(negedge clk) begin
		out_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// send one triangle beat, with a random gap in front of it
	task automatic send_tri(crd_t xa, crd_t ya, crd_t xb, crd_t yb, crd_t xc, crd_t yc,
			logic marked);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		x_a <= xa; y_a <= ya; x_b <= xb; y_b <= yb; x_c <= xc; y_c <= yc;
		is_triangle <= marked;
		do @(posedge clk); while (!in_ready);
		matrix_q.push_back(stiffness_of(xa, ya, xb, yb, xc, yc, marked, k_model));
	endtask

	// let every beat drain, then leave the pipeline quiet for a while
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (matrix_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// conductivity write, only with the pipeline empty
	task automatic write_k(logic [thstf_pkg::K_W-1:0] k);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= k;
		do @(posedge clk); while (!cfg_ready);
		k_model = k;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic crd_t small_crd();
		return crd_t'($signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000);
	endfunction

	task automatic test_extremes();
		crd_t mx, mn;
		mx = 32'sh7FFFFFFF;
		mn = 32'sh80000000;
		send_tri(0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b1);
		send_tri(0, 0, 0, 32'sh10000, 32'sh10000, 0, 1'b1);
		send_tri(mn, mn, mx, mn, mn, mx, 1'b1);
		send_tri(mx, mx, mn, mx, mx, mn, 1'b1);
		send_tri(mn, mx, mx, mx, mx, mn, 1'b1);
		// tiny triangle, then slivers: huge entries, saturation both ways
		send_tri(0, 0, 1, 0, 0, 1, 1'b1);
		send_tri(0, 0, mx, 0, 0, 1, 1'b1);
		send_tri(mx, 0, mn, 1, 0, 0, 1'b1);
		send_tri(32'sh7FFF0000, 32'sh12345, -32'sh1, 32'sh55555555, 32'sh0, -32'sh3, 1'b1);
	endtask

	task automatic test_degenerate();
		send_tri(0, 0, 0, 0, 0, 0, 1'b1);
		send_tri(32'sh10000, 32'sh20000, 32'sh20000, 32'sh40000, 32'sh30000, 32'sh60000,
			1'b1);
		send_tri(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 5, 5, 1'b1);
		send_tri(-7, 3, -7, 3, -7, 3, 1'b1);
	endtask

	task automatic test_not_triangle();
		send_tri(0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b0);
		send_tri(32'sh80000000, 32'sh7FFFFFFF, 1, 2, 3, 4, 1'b0);
		send_tri(0, 0, 0, 0, 0, 0, 1'b0);
	endtask

	task automatic test_conductivity();
		write_k('0);
		send_tri(0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b1);
		send_tri(0, 0, 1, 0, 0, 1, 1'b1);
		write_k('1);
		send_tri(0, 0, 32'sh10000, 0, 0, 32'sh10000, 1'b1);
		send_tri(0, 0, 1, 0, 0, 1, 1'b1);
		send_tri(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			32'sh80000000, 32'sh7FFFFFFF, 1'b1);
	endtask

	// random triangles: mostly moderate sizes, some full range, collinear and unmarked
	task automatic test_random(int count);
		crd_t xa, ya, xb, yb, xc, yc;
		int sel, t;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 60) begin
				xa = small_crd(); ya = small_crd(); xb = small_crd();
				yb = small_crd(); xc = small_crd(); yc = small_crd();
			end else begin
				xa = $urandom(); ya = $urandom(); xb = $urandom();
				yb = $urandom(); xc = $urandom(); yc = $urandom();
			end
			if (sel >= 80 && sel < 90) begin
				// third corner on the line through the first two
				t = $urandom_range(0, 6) - 3;
				xa = small_crd(); ya = small_crd();
				xb = small_crd(); yb = small_crd();
				xc = xa + t * (xb - xa);
				yc = ya + t * (yb - ya);
			end
			send_tri(xa, ya, xb, yb, xc, yc, sel < 90 ? 1'b1 : 1'b0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_degenerate();
		test_not_triangle();
		test_conductivity();
		write_k($urandom());
		test_random(200);
		// long stretch with no idling on either side
		no_idle = 1'b1;
		test_random(150);
		no_idle = 1'b0;
		write_k(thstf_pkg::K_RESET);
		test_random(150);
		write_k($urandom_range(1, 32'h3FFFF));
		test_random(150);
		drain();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/thstf_pkg.sv
rtl/thstf_div.sv
rtl/triangle_heat_stiffness.sv
tb/tb.sv
